// ===== design/dls_pkg.sv =====
// shared widths, register indexes and drive clamp for the dual lift sync block
package dls_pkg;

   localparam int POS_BITS  = 12;
   localparam int TARGET_W  = 13;
   localparam int GAIN_W    = 4;
   localparam int SLEW_W    = 7;
   localparam int DRIVE_W   = 8;
   localparam int DTGT_W    = DRIVE_W + 1;
   localparam int DRIVE_MAX = 127;

   // position error and its product with the gain
   localparam int DIFF_W = ((POS_BITS + 1 > TARGET_W) ? POS_BITS + 1 : TARGET_W) + 1;
   localparam int PROD_W = DIFF_W + GAIN_W + 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = TARGET_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET = 2'd0,
      CSR_GAIN   = 2'd1,
      CSR_SLEW   = 2'd2
   } csr_index_type;

   typedef logic [POS_BITS-1:0]       pos_type;
   typedef logic signed [DRIVE_W-1:0] drive_type;
   typedef logic signed [DTGT_W-1:0]  dtgt_type;
   typedef logic signed [PROD_W-1:0]  wide_type;

   localparam wide_type CLAMP_HI = PROD_W'(DRIVE_MAX);
   localparam wide_type CLAMP_LO = -CLAMP_HI;

   function automatic drive_type clamp_drive(input wide_type v);
      drive_type r;
      if (v < CLAMP_LO) begin
         r = DRIVE_W'(CLAMP_LO);
      end else if (v > CLAMP_HI) begin
         r = DRIVE_W'(CLAMP_HI);
      end else begin
         r = DRIVE_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== design/dls_if.sv =====
// valid/ready channel interfaces for position samples and drive results
interface dls_req_if;
   import dls_pkg::*;

   logic    valid;
   logic    ready;
   pos_type left_position;
   pos_type right_position;

   modport source (output valid, left_position, right_position, input ready);
   modport sink   (input valid, left_position, right_position, output ready);
endinterface

interface dls_rsp_if;
   import dls_pkg::*;

   logic      valid;
   logic      ready;
   drive_type left_drive;
   drive_type right_drive;
   dtgt_type  left_target;
   dtgt_type  right_target;

   modport source (output valid, left_drive, right_drive, left_target, right_target,
                   input ready);
   modport sink   (input valid, left_drive, right_drive, left_target, right_target,
                   output ready);
endinterface

// ===== design/dual_lift_sync_p_slew_core.sv =====
// Dual lift sync controller: cross-coupled proportional drive with slew limit.
//
// req_ch carries one control tick: the left and right lift position samples.
// rsp_ch returns one result per tick: the slewed left/right drives and the
// unslewed drive targets they moved toward.
// csr_* writes target_value (0), gain (1) and slew_step (2); other indexes
// are ignored. Write only while no tick is in flight.
//
// A tick is captured into an input stage register; its targets and new
// slewed drives are then formed combinationally and loaded into the result
// register, from which the result shows on rsp_ch. One tick is taken every
// cycle while the receiver keeps up; the slewed drive state is read and
// rewritten in the second stage as each tick advances.
//
// When the receiver stalls, the result register holds, the input stage
// fills and then req_ch.ready drops; no tick is lost or repeated.
// Reset clears both stages, sets the slewed drives to zero and loads the
// registers with target 0, gain 1 and slew step 8.
module dual_lift_sync_p_slew_core (
   input  logic                              clock,
   input  logic                              reset,
   dls_req_if.sink                           req_ch,
   dls_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [dls_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dls_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dls_pkg::*;

   logic signed [TARGET_W-1:0] target_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic [SLEW_W-1:0]          slew_ff;

   logic    stg_valid_ff, stg_valid_in;
   pos_type stg_left_ff, stg_right_ff;

   logic      out_valid_ff, out_valid_in;
   dtgt_type  out_left_tgt_ff, out_right_tgt_ff;
   drive_type left_slewed_ff, left_slewed_in;
   drive_type right_slewed_ff, right_slewed_in;

   dtgt_type left_tgt, right_tgt;
   logic     stg_advance;
   logic     req_xfer;

   // base drive plus sync term for one side
   function automatic dtgt_type side_target(input pos_type own, input pos_type other,
                                            input logic signed [TARGET_W-1:0] tv,
                                            input logic [GAIN_W-1:0] g);
      logic signed [DIFF_W-1:0]   own_ext;
      logic signed [DIFF_W-1:0]   tv_ext;
      logic signed [DIFF_W-1:0]   err;
      logic signed [GAIN_W:0]     g_s;
      wide_type                   prod;
      logic signed [POS_BITS:0]   sync;
      drive_type                  base;
      drive_type                  sync_c;
      own_ext = $signed({{(DIFF_W - POS_BITS){1'b0}}, own});
      tv_ext  = $signed({{(DIFF_W - TARGET_W){tv[TARGET_W-1]}}, tv});
      err     = tv_ext - own_ext;
      g_s     = $signed({1'b0, g});
      prod    = err * g_s;
      sync    = $signed({1'b0, other}) - $signed({1'b0, own});
      // position mode when |target| is above the drive range
      if (tv > $signed(TARGET_W'(DRIVE_MAX)) || tv < -$signed(TARGET_W'(DRIVE_MAX))) begin
         base = clamp_drive(prod);
      end else begin
         base = DRIVE_W'(tv);
      end
      sync_c = clamp_drive(PROD_W'(sync));
      return $signed({base[DRIVE_W-1], base}) + $signed({sync_c[DRIVE_W-1], sync_c});
   endfunction

   function automatic drive_type slew_toward(input dtgt_type goal, input drive_type cur,
                                             input logic [SLEW_W-1:0] step);
      logic signed [DTGT_W:0] d;
      logic signed [DTGT_W:0] step_s;
      logic signed [DTGT_W:0] sum;
      d      = $signed({goal[DTGT_W-1], goal}) - $signed({{2{cur[DRIVE_W-1]}}, cur});
      step_s = $signed({{(DTGT_W + 1 - SLEW_W){1'b0}}, step});
      if (d > step_s) begin
         d = step_s;
      end else if (d < -step_s) begin
         d = -step_s;
      end
      sum = $signed({{2{cur[DRIVE_W-1]}}, cur}) + d;
      return clamp_drive(PROD_W'(sum));
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         gain_ff   <= GAIN_W'(1);
         slew_ff   <= SLEW_W'(8);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET: target_ff <= $signed(csr_wdata[TARGET_W-1:0]);
            CSR_GAIN:   gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_SLEW:   slew_ff   <= csr_wdata[SLEW_W-1:0];
            default:    ;
         endcase
      end
   end

   assign stg_advance   = stg_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !stg_valid_ff || stg_advance;
   assign req_xfer      = req_ch.valid && req_ch.ready;

   always_comb begin
      left_tgt        = side_target(stg_left_ff, stg_right_ff, target_ff, gain_ff);
      right_tgt       = side_target(stg_right_ff, stg_left_ff, target_ff, gain_ff);
      left_slewed_in  = slew_toward(left_tgt, left_slewed_ff, slew_ff);
      right_slewed_in = slew_toward(right_tgt, right_slewed_ff, slew_ff);
      stg_valid_in    = req_xfer || (stg_valid_ff && !stg_advance);
      out_valid_in    = stg_advance || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
         left_slewed_ff  <= '0;
         right_slewed_ff <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
         if (stg_advance) begin
            left_slewed_ff  <= left_slewed_in;
            right_slewed_ff <= right_slewed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stg_left_ff  <= req_ch.left_position;
         stg_right_ff <= req_ch.right_position;
      end
      if (stg_advance) begin
         out_left_tgt_ff  <= left_tgt;
         out_right_tgt_ff <= right_tgt;
      end
   end

   // the slewed drive state doubles as the result drive fields
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.left_drive   = left_slewed_ff;
   assign rsp_ch.right_drive  = right_slewed_ff;
   assign rsp_ch.left_target  = out_left_tgt_ff;
   assign rsp_ch.right_target = out_right_tgt_ff;

`ifndef SYNTHESIS
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> $stable(left_slewed_ff) && $stable(right_slewed_ff))
      else $error("slewed drive changed while result stalled");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      left_slewed_ff >= -$signed(DRIVE_W'(DRIVE_MAX)) &&
      left_slewed_ff <= $signed(DRIVE_W'(DRIVE_MAX)) &&
      right_slewed_ff >= -$signed(DRIVE_W'(DRIVE_MAX)) &&
      right_slewed_ff <= $signed(DRIVE_W'(DRIVE_MAX)))
      else $error("slewed drive out of range");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && out_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken while both stages are full");

   a_advance_loads_result: assert property (@(posedge clock) disable iff (reset)
      stg_advance |=> out_valid_ff && rsp_ch.left_target == $past(left_tgt))
      else $error("result register missed an advancing tick");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the dual lift sync controller
module tb_top;
   import dls_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RANDOM_TICKS = 1150;
   localparam int PRINT_CAP    = 60;
   localparam int POS_MAX      = (1 << POS_BITS) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      drive_type left_drive;
      drive_type right_drive;
      dtgt_type  left_target;
      dtgt_type  right_target;
   } drive_result_type;

   typedef struct {
      int tgt;
      int gn;
      int sl;
      bit spare_write;
      int lp;
      int rp;
      bit known;
      int ld;
      int rd;
      int lt;
      int rt;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dls_req_if req_ch ();
   dls_rsp_if rsp_ch ();

   dual_lift_sync_p_slew_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow of the control registers and of the slewed drives
   int shadow_target;
   int shadow_gain;
   int shadow_slew;
   int slewed_left;
   int slewed_right;

   drive_result_type pending_drives[$];
   drive_result_type rsp_want;
   int fault_count;
   int ticks_sent;
   int results_checked;
   int settings_used;
   int rx_cycle;

   // directed ticks; known rows carry a hand-worked result
   plan_row_type plan [21] = '{
      '{0,     1,  8,   0, 0,    0,    1, 0,    0,    0,    0},
      '{0,     1,  8,   0, 0,    4095, 1, 8,    -8,   127,  -127},
      '{0,     1,  8,   0, 4095, 0,    1, 0,    0,    -127, 127},
      '{127,   1,  127, 0, 2048, 2048, 1, 127,  127,  127,  127},
      '{127,   1,  127, 0, 0,    4095, 1, 127,  0,    254,  0},
      '{-127,  1,  127, 0, 4095, 0,    1, 0,    0,    -254, 0},
      '{-127,  1,  127, 0, 4095, 0,    1, -127, 0,    -254, 0},
      '{128,   1,  127, 0, 0,    0,    1, 0,    127,  127,  127},
      '{-128,  1,  127, 0, 4095, 4095, 1, -127, 0,    -127, -127},
      '{4095,  15, 127, 0, 4095, 4095, 1, 0,    0,    0,    0},
      '{4095,  15, 127, 0, 4000, 4095, 1, 127,  -95,  222,  -95},
      '{-4095, 15, 1,   0, 0,    100,  1, 126,  -96,  -27,  -227},
      '{3000,  0,  127, 0, 1000, 1200, 1, 127,  -127, 127,  -127},
      '{3000,  0,  127, 0, 1234, 1234, 1, 0,    0,    0,    0},
      '{100,   1,  0,   0, 0,    0,    1, 0,    0,    100,  100},
      '{100,   1,  0,   0, 0,    4095, 1, 0,    0,    227,  -27},
      '{100,   1,  0,   1, 2048, 2047, 1, 0,    0,    99,   101},
      '{0,     1,  1,   0, 2730, 1365, 1, -1,   1,    -127, 127},
      '{0,     1,  1,   0, 1365, 2730, 1, 0,    0,    127,  -127},
      '{2000,  3,  20,  0, 1990, 2010, 0, 0,    0,    0,    0},
      '{-50,   7,  64,  0, 17,   3000, 0, 0,    0,    0,    0}
   };

   function automatic int limit_drive(int v);
      if (v < -DRIVE_MAX) begin
         return -DRIVE_MAX;
      end
      if (v > DRIVE_MAX) begin
         return DRIVE_MAX;
      end
      return v;
   endfunction

   function automatic int step_toward(int goal, int cur, int step);
      int d;
      d = goal - cur;
      if (d > step) begin
         d = step;
      end else if (d < -step) begin
         d = -step;
      end
      return limit_drive(cur + d);
   endfunction

   // position mode above the direct speed range, then the cross-coupling term
   function automatic int side_goal(int own, int other);
      int base;
      int mag;
      mag = (shadow_target < 0) ? -shadow_target : shadow_target;
      if (mag > DRIVE_MAX) begin
         base = limit_drive(shadow_gain * (shadow_target - own));
      end else begin
         base = shadow_target;
      end
      return base + limit_drive(other - own);
   endfunction

   task automatic predict_tick(input pos_type lp, input pos_type rp,
                               output drive_result_type r);
      int lt;
      int rt;
      lt = side_goal(int'(lp), int'(rp));
      rt = side_goal(int'(rp), int'(lp));
      slewed_left  = step_toward(lt, slewed_left, shadow_slew);
      slewed_right = step_toward(rt, slewed_right, shadow_slew);
      r.left_drive   = drive_type'(slewed_left);
      r.right_drive  = drive_type'(slewed_right);
      r.left_target  = dtgt_type'(lt);
      r.right_target = dtgt_type'(rt);
   endtask

   function automatic pos_type pick_position(int center, int spread);
      int p;
      p = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (p < 0) begin
         p = 0;
      end else if (p > POS_MAX) begin
         p = POS_MAX;
      end
      return pos_type'(p);
   endfunction

   function automatic pos_type corner_position();
      int c;
      c = $urandom_range(0, 2);
      if (c == 0) begin
         return '0;
      end else if (c == 1) begin
         return pos_type'(POS_MAX);
      end
      return pos_type'($urandom);
   endfunction

   task automatic report_fault(string msg);
      fault_count++;
      if (fault_count <= PRINT_CAP) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      case (idx)
         CSR_TARGET: shadow_target = int'($signed(data[TARGET_W-1:0]));
         CSR_GAIN:   shadow_gain   = int'(data[GAIN_W-1:0]);
         CSR_SLEW:   shadow_slew   = int'(data[SLEW_W-1:0]);
         default: ;
      endcase
   endtask

   // upper bits of the narrow registers carry junk, only the low bits count
   task automatic apply_setting(int tgt, int gn, int sl, bit spare);
      write_reg(CSR_TARGET, CSR_DATA_W'(tgt));
      write_reg(CSR_GAIN, CSR_DATA_W'(($urandom << GAIN_W) | gn));
      write_reg(CSR_SLEW, CSR_DATA_W'(($urandom << SLEW_W) | sl));
      if (spare) begin
         write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      end
      @(negedge clock);
      csr_we = 1'b0;
      settings_used++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_drives.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic pause_sender(int n);
      if (n == 0) begin
         return;
      end
      @(negedge clock);
      req_ch.valid = 1'b0;
      req_ch.left_position  = pos_type'($urandom);
      req_ch.right_position = pos_type'($urandom);
      repeat (n - 1) begin
         @(negedge clock);
         req_ch.left_position  = pos_type'($urandom);
         req_ch.right_position = pos_type'($urandom);
      end
   endtask

   task automatic send_tick(pos_type lp, pos_type rp, bit known,
                            drive_result_type typed_want);
      drive_result_type want;
      @(negedge clock);
      req_ch.valid          = 1'b1;
      req_ch.left_position  = lp;
      req_ch.right_position = rp;
      do @(posedge clock); while (!req_ch.ready);
      predict_tick(lp, rp, want);
      if (known) begin
         pending_drives.push_back(typed_want);
      end else begin
         pending_drives.push_back(want);
      end
      ticks_sent++;
   endtask

   // receiver stall pattern, stepping through four characters in turn
   always @(negedge clock) begin
      rx_cycle++;
      case ((rx_cycle / 256) % 4)
         0: rsp_ch.ready = 1'b1;
         1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready = $urandom_range(0, 1);
         default: rsp_ch.ready = ((rx_cycle % 13) < 5);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_drives.size() == 0) begin
            report_fault($sformatf("result with no tick pending: drive L %0d R %0d",
                                   rsp_ch.left_drive, rsp_ch.right_drive));
         end else begin
            rsp_want = pending_drives.pop_front();
            results_checked++;
            if (rsp_ch.left_drive !== rsp_want.left_drive ||
                rsp_ch.right_drive !== rsp_want.right_drive ||
                rsp_ch.left_target !== rsp_want.left_target ||
                rsp_ch.right_target !== rsp_want.right_target) begin
               report_fault($sformatf(
                  "drive L %0d/%0d R %0d/%0d target L %0d/%0d R %0d/%0d (got/want)",
                  rsp_ch.left_drive, rsp_want.left_drive,
                  rsp_ch.right_drive, rsp_want.right_drive,
                  rsp_ch.left_target, rsp_want.left_target,
                  rsp_ch.right_target, rsp_want.right_target));
            end
         end
      end
   end

   initial begin
      plan_row_type     row;
      drive_result_type typed;
      drive_result_type none;
      pos_type          lp;
      pos_type          rp;
      int               tgt;
      int               gn;
      int               sl;
      int               phase_ticks;
      int               burst_left;
      int               gap_free;
      int               shape;
      int               center;
      int               spread;
      int               directed_count;

      req_ch.valid          = 1'b0;
      req_ch.left_position  = '0;
      req_ch.right_position = '0;
      rsp_ch.ready          = 1'b0;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      shadow_target = 0;
      shadow_gain   = 1;
      shadow_slew   = 8;
      slewed_left   = 0;
      slewed_right  = 0;
      none = '{default: '0};
      directed_count = $size(plan);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < directed_count; i++) begin
         row = plan[i];
         if (row.tgt != shadow_target || row.gn != shadow_gain ||
             row.sl != shadow_slew || row.spare_write) begin
            wait_drained();
            apply_setting(row.tgt, row.gn, row.sl, row.spare_write);
         end
         typed.left_drive   = drive_type'(row.ld);
         typed.right_drive  = drive_type'(row.rd);
         typed.left_target  = dtgt_type'(row.lt);
         typed.right_target = dtgt_type'(row.rt);
         send_tick(pos_type'(row.lp), pos_type'(row.rp), row.known, typed);
      end

      while (ticks_sent < directed_count + RANDOM_TICKS) begin
         case ($urandom_range(0, 9))
            0: tgt = 4095;
            1: tgt = -4095;
            2: tgt = DRIVE_MAX;
            3: tgt = -DRIVE_MAX;
            4: tgt = DRIVE_MAX + 1;
            5: tgt = -DRIVE_MAX - 1;
            6, 7: tgt = int'($urandom_range(0, 2 * DRIVE_MAX)) - DRIVE_MAX;
            default: tgt = int'($urandom_range(0, 8190)) - 4095;
         endcase
         case ($urandom_range(0, 5))
            0: gn = 0;
            1: gn = 15;
            default: gn = $urandom_range(0, 15);
         endcase
         case ($urandom_range(0, 7))
            0: sl = 1;
            1: sl = 127;
            2: sl = 0;
            default: sl = $urandom_range(1, 127);
         endcase
         wait_drained();
         apply_setting(tgt, gn, sl, $urandom_range(0, 5) == 0);

         phase_ticks = $urandom_range(20, 90);
         gap_free    = ($urandom_range(0, 3) == 0);
         shape       = $urandom_range(0, 3);
         spread      = $urandom_range(4, 300);
         // track around the setpoint so the error term stays out of saturation
         if (tgt >= 0 && tgt <= POS_MAX) begin
            center = tgt;
         end else begin
            center = $urandom_range(0, POS_MAX);
         end
         burst_left = 0;
         repeat (phase_ticks) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (!gap_free) begin
                  pause_sender($urandom_range(0, 6));
               end
            end
            burst_left--;
            if ($urandom_range(0, 99) == 0) begin
               wait_drained();
            end
            case (shape)
               0: begin
                  lp = pos_type'($urandom);
                  rp = pos_type'($urandom);
               end
               1: begin
                  lp = pick_position(center, spread);
                  rp = pick_position(int'(lp), spread / 2);
               end
               2: begin
                  lp = pos_type'($urandom);
                  rp = pick_position(int'(lp), 40);
               end
               default: begin
                  lp = corner_position();
                  rp = corner_position();
               end
            endcase
            send_tick(lp, rp, 1'b0, none);
         end
      end

      wait_drained();
      repeat (5) @(posedge clock);
      $display("%0d position ticks under %0d register settings, %0d results compared",
               ticks_sent, settings_used, results_checked);
      $display("%0d mismatching or unexpected results", fault_count);
      if (fault_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout with %0d results still pending", pending_drives.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
